FILE: rtl/ste_pkg.sv
// Shared definitions for the segment text encoder: display size, command
// kinds passed from the front end to the back end, and the glyph tables.
// No dependencies.
`timescale 1ns / 1ps

package ste_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int POS_W      = $clog2(NUM_DIGITS + 1);

  // Command kinds produced by the character classifier.
  localparam logic [2:0] KIND_TAKE  = 3'd0;
  localparam logic [2:0] KIND_DOT   = 3'd1;
  localparam logic [2:0] KIND_COLON = 3'd2;
  localparam logic [2:0] KIND_PCT   = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  // Character codes with special meaning.
  localparam logic [7:0] CHAR_DOT     = 8'd46;
  localparam logic [7:0] CHAR_COLON   = 8'd58;
  localparam logic [7:0] CHAR_PERCENT = 8'd37;
  localparam logic [7:0] CHAR_STAR    = 8'd42;
  localparam logic [7:0] CHAR_MINUS   = 8'd45;
  localparam logic [7:0] CHAR_QUOTE   = 8'd34;
  localparam logic [7:0] CHAR_SLASH   = 8'd47;
  localparam logic [7:0] CHAR_EQUAL   = 8'd61;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_SIGN_LO = 8'd65;
  localparam logic [7:0] CHAR_SIGN_HI = 8'd125;

  localparam logic [7:0] GLYPH_STAR      = 8'hF0;
  localparam logic [7:0] GLYPH_MINUS     = 8'h80;
  localparam logic [7:0] GLYPH_QUOTE     = 8'h50;
  localparam logic [7:0] GLYPH_SLASH     = 8'h12;
  localparam logic [7:0] GLYPH_EQUAL     = 8'hA0;
  localparam logic [7:0] GLYPH_PCT_LEFT  = 8'hF0;
  localparam logic [7:0] GLYPH_PCT_RIGHT = 8'hCE;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] glyph;
  } cmd_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:    g = 8'h7E;
      4'd1:    g = 8'h12;
      4'd2:    g = 8'hBC;
      4'd3:    g = 8'hB6;
      4'd4:    g = 8'hD2;
      4'd5:    g = 8'hE6;
      4'd6:    g = 8'hEE;
      4'd7:    g = 8'h32;
      4'd8:    g = 8'hFE;
      4'd9:    g = 8'hF6;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Letters and signs, indexed from 'A'.
  function automatic logic [7:0] sign_glyph(input logic [5:0] idx);
    logic [7:0] g;
    case (idx)
      6'd0:  g = 8'hFA; 6'd1:  g = 8'hFE; 6'd2:  g = 8'h6C; 6'd3:  g = 8'h7E;
      6'd4:  g = 8'hEC; 6'd5:  g = 8'hE8; 6'd6:  g = 8'hEE; 6'd7:  g = 8'hDA;
      6'd8:  g = 8'h48; 6'd9:  g = 8'h3E; 6'd11: g = 8'h4C; 6'd13: g = 8'h7A;
      6'd14: g = 8'h7E; 6'd15: g = 8'hF8; 6'd17: g = 8'h68; 6'd18: g = 8'hE6;
      6'd19: g = 8'hCC; 6'd20: g = 8'h5E; 6'd24: g = 8'hD6; 6'd26: g = 8'h6C;
      6'd27: g = 8'h18; 6'd28: g = 8'h36; 6'd29: g = 8'h70; 6'd30: g = 8'h04;
      6'd32: g = 8'hFA; 6'd33: g = 8'hCE; 6'd34: g = 8'h8C; 6'd35: g = 8'h9E;
      6'd36: g = 8'hEC; 6'd37: g = 8'hE8; 6'd38: g = 8'hF6; 6'd39: g = 8'hCA;
      6'd40: g = 8'h08; 6'd41: g = 8'h3E; 6'd43: g = 8'h48; 6'd45: g = 8'h8A;
      6'd46: g = 8'h8E; 6'd47: g = 8'hF8; 6'd48: g = 8'hF2; 6'd49: g = 8'h88;
      6'd50: g = 8'hE6; 6'd51: g = 8'hCC; 6'd52: g = 8'h0E; 6'd56: g = 8'hD6;
      6'd59: g = 8'h48;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/segment_text_encoder.sv
// Top level of the seven-segment text encoder: joins the classifying front
// end, the command queue and the back end. Depends on ste_pkg and the three
// ste_ submodules.
`timescale 1ns / 1ps

// The encoder turns a stream of text characters into one 8-bit segment code
// per display position, for a display of NUM_DIGITS positions (ste_pkg).
// Each input request carries a character in s_axis_tdata, or, with
// s_axis_tuser high, an end-of-text marker. Bit 0 of every segment code is
// the decimal point: a '.' sets the dot of the previous position, a ':' sets
// it and also the dot of the following position, and a '%' fills two
// positions. Because a following dot may still change it, the most recent
// position is held back and only emitted when the next position-taking
// character or the end marker arrives; the end marker flushes it, fills the
// remaining positions with blanks (a pending colon dot lands on the first
// blank), marks the final result with m_axis_tlast and returns the encoder
// to its reset state. Unknown characters give a blank position and positions
// beyond the display are dropped. Throughput: the front end classifies one
// character per cycle into a two-entry queue while the queue is not full;
// the back end, which owns the single result register, carries out a '%' by
// first flushing the held position and then emitting the left half, and an
// end marker by emitting the remaining positions, one position per cycle as
// long as each result is taken. While a result waits on m_axis_tready the
// back end stalls, but the queue still lets further requests be taken.
module segment_text_encoder import ste_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] operation (1 = end of text)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] digit_index, [10:3] segments, rest zero
  output logic        m_axis_tlast    // last position of an end-of-text flush
);

  logic       push;
  cmd_t       push_cmd;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  cmd_t       head_cmd;
  logic [2:0] digit_index;
  logic [7:0] segments;

  ste_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_end     (s_axis_tuser),
    .in_char    (s_axis_tdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  ste_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ste_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_index    (digit_index),
    .out_segments (segments),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, segments, digit_index};

endmodule

FILE: rtl/ste_front.sv
// Front end of the segment text encoder: classifies each incoming request
// into a command and pushes it into the command queue. Depends on ste_pkg.
`timescale 1ns / 1ps

module ste_front import ste_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_end,
  input  logic [7:0] in_char,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       queue_full
);

  logic [5:0] sign_off;
  logic [3:0] digit_off;

  assign in_ready  = !queue_full;
  assign push      = in_valid && !queue_full;
  assign sign_off  = 6'(in_char - CHAR_SIGN_LO);
  assign digit_off = 4'(in_char - CHAR_ZERO);

  always_comb begin
    push_cmd.kind  = KIND_TAKE;
    push_cmd.glyph = 8'h00;
    if (in_end) begin
      push_cmd.kind = KIND_END;
    end else begin
      case (in_char) inside
        [CHAR_ZERO:CHAR_NINE]:       push_cmd.glyph = digit_glyph(digit_off);
        [CHAR_SIGN_LO:CHAR_SIGN_HI]: push_cmd.glyph = sign_glyph(sign_off);
        CHAR_DOT:     push_cmd.kind  = KIND_DOT;
        CHAR_COLON:   push_cmd.kind  = KIND_COLON;
        CHAR_PERCENT: push_cmd.kind  = KIND_PCT;
        CHAR_STAR:    push_cmd.glyph = GLYPH_STAR;
        CHAR_MINUS:   push_cmd.glyph = GLYPH_MINUS;
        CHAR_QUOTE:   push_cmd.glyph = GLYPH_QUOTE;
        CHAR_SLASH:   push_cmd.glyph = GLYPH_SLASH;
        CHAR_EQUAL:   push_cmd.glyph = GLYPH_EQUAL;
        default:      push_cmd.glyph = 8'h00;
      endcase
    end
  end

endmodule

FILE: rtl/ste_queue.sv
// Two-entry command queue between the front end and the back end of the
// segment text encoder. Depends on ste_pkg for the command type.
`timescale 1ns / 1ps

module ste_queue import ste_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entry[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/ste_back.sv
// Back end of the segment text encoder: holds the display state, carries out
// queued commands and drives the registered result stage. Depends on ste_pkg.
`timescale 1ns / 1ps

module ste_back import ste_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_index,
  output logic [7:0] out_segments,
  output logic       out_last
);

  localparam logic [POS_W-1:0] POS_FULL = POS_W'(NUM_DIGITS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

  logic [7:0]       held_code;
  logic [7:0]       held_code_next;
  logic             held_valid;
  logic             held_valid_next;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic             colon_pending;
  logic             colon_pending_next;
  logic             pct_half;
  logic             pct_half_next;

  logic             go;
  logic             emit;
  logic [7:0]       emit_code;
  logic             emit_last;
  logic             pos_full;

  assign go       = head_valid && (!out_valid || out_ready);
  assign pos_full = (position == POS_FULL);

  always_comb begin
    held_code_next     = held_code;
    held_valid_next    = held_valid;
    position_next      = position;
    colon_pending_next = colon_pending;
    pct_half_next      = pct_half;
    emit               = 1'b0;
    emit_code          = held_code;
    emit_last          = 1'b0;
    pop                = 1'b0;
    if (go) begin
      unique case (head_cmd.kind)
        KIND_TAKE: begin
          if (held_valid && !pos_full) begin
            emit          = 1'b1;
            position_next = position + POS_ONE;
          end
          held_code_next     = head_cmd.glyph | {7'd0, colon_pending};
          held_valid_next    = 1'b1;
          colon_pending_next = 1'b0;
          pop                = 1'b1;
        end
        KIND_DOT: begin
          if (held_valid) begin
            held_code_next[0] = 1'b1;
          end
          pop = 1'b1;
        end
        KIND_COLON: begin
          if (held_valid) begin
            held_code_next[0] = 1'b1;
          end
          colon_pending_next = 1'b1;
          pop                = 1'b1;
        end
        KIND_PCT: begin
          if (!pct_half) begin
            // First half: flush the held position.
            if (held_valid && !pos_full) begin
              emit          = 1'b1;
              position_next = position + POS_ONE;
            end
            held_valid_next = 1'b0;
            pct_half_next   = 1'b1;
          end else begin
            // Second half: emit the left glyph, hold the right one.
            if (!pos_full) begin
              emit          = 1'b1;
              emit_code     = GLYPH_PCT_LEFT;
              position_next = position + POS_ONE;
            end
            held_code_next     = GLYPH_PCT_RIGHT | {7'd0, colon_pending};
            held_valid_next    = 1'b1;
            colon_pending_next = 1'b0;
            pct_half_next      = 1'b0;
            pop                = 1'b1;
          end
        end
        KIND_END: begin
          if (!pos_full) begin
            emit      = 1'b1;
            emit_code = held_valid ? held_code : {7'd0, colon_pending};
            emit_last = (position == POS_LAST);
            if (held_valid) begin
              held_valid_next = 1'b0;
            end else begin
              colon_pending_next = 1'b0;
            end
            position_next = position + POS_ONE;
          end
          if (pos_full || position == POS_LAST) begin
            pop                = 1'b1;
            held_code_next     = 8'h00;
            held_valid_next    = 1'b0;
            position_next      = '0;
            colon_pending_next = 1'b0;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code     <= 8'h00;
      held_valid    <= 1'b0;
      position      <= '0;
      colon_pending <= 1'b0;
      pct_half      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      held_code     <= held_code_next;
      held_valid    <= held_valid_next;
      position      <= position_next;
      colon_pending <= colon_pending_next;
      pct_half      <= pct_half_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index    <= 3'(position);
      out_segments <= emit_code;
      out_last     <= emit_last;
    end
  end

endmodule

FILE: bench/tb.sv
// Self-checking bench for segment_text_encoder: drives text requests on the
// slave stream and checks every emitted display position on the master stream.
// Depends on ste_pkg and the encoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb import ste_pkg::*; ();

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam int TEXT_REQUESTS  = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * NUM_DIGITS + 10;

  // Glyphs for '0'..'9', then for the letters and signs from 'A' to '}'.
  localparam logic [7:0] NUMBER_GLYPHS [0:9] = '{
    8'h7E, 8'h12, 8'hBC, 8'hB6, 8'hD2, 8'hE6, 8'hEE, 8'h32, 8'hFE, 8'hF6
  };
  localparam logic [7:0] LETTER_GLYPHS [0:60] = '{
    8'hFA, 8'hFE, 8'h6C, 8'h7E, 8'hEC, 8'hE8, 8'hEE, 8'hDA, 8'h48, 8'h3E,
    8'h00, 8'h4C, 8'h00, 8'h7A, 8'h7E, 8'hF8, 8'h00, 8'h68, 8'hE6, 8'hCC,
    8'h5E, 8'h00, 8'h00, 8'h00, 8'hD6, 8'h00, 8'h6C, 8'h18, 8'h36, 8'h70,
    8'h04, 8'h00, 8'hFA, 8'hCE, 8'h8C, 8'h9E, 8'hEC, 8'hE8, 8'hF6, 8'hCA,
    8'h08, 8'h3E, 8'h00, 8'h48, 8'h00, 8'h8A, 8'h8E, 8'hF8, 8'hF2, 8'h88,
    8'hE6, 8'hCC, 8'h0E, 8'h00, 8'h00, 8'h00, 8'hD6, 8'h00, 8'h00, 8'h48,
    8'h00
  };

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } text_req_t;

  typedef struct packed {
    logic [2:0] digit_index;
    logic [7:0] segments;
    logic       last;
  } position_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
  logic        s_axis_tuser = 1'b0;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [2:0] digit_index, [10:3] segments
  logic        m_axis_tlast;

  segment_text_encoder dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_req_t text_queue[$];
  position_t expected_positions[$];

  int total_requests    = TEXT_REQUESTS;
  int accepted_requests = 0;
  int end_requests      = 0;
  int checked_positions = 0;
  int errors            = 0;
  int quiet_cycles      = 0;

  // Shadow of the encoder state.
  logic [7:0] held_glyph;
  logic       held_valid;
  int         write_pos;
  logic       colon_pending;
  int         request_results;

  // Glyph of a character that takes one position; anything unknown is blank.
  function automatic logic [7:0] glyph_of_char(input logic [7:0] ch);
    logic [7:0] g;
    g = 8'h00;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
      g = NUMBER_GLYPHS[ch - CHAR_ZERO];
    else if (ch >= CHAR_SIGN_LO && ch <= CHAR_SIGN_HI)
      g = LETTER_GLYPHS[ch - CHAR_SIGN_LO];
    else if (ch == CHAR_STAR)  g = GLYPH_STAR;
    else if (ch == CHAR_MINUS) g = GLYPH_MINUS;
    else if (ch == CHAR_QUOTE) g = GLYPH_QUOTE;
    else if (ch == CHAR_SLASH) g = GLYPH_SLASH;
    else if (ch == CHAR_EQUAL) g = GLYPH_EQUAL;
    return g;
  endfunction

  // Positions past the right-hand end of the display are dropped.
  task automatic emit_position(input logic [7:0] glyph);
    position_t p;
    if (write_pos < NUM_DIGITS) begin
      p.digit_index = write_pos[2:0];
      p.segments    = glyph;
      p.last        = 1'b0;
      expected_positions.push_back(p);
      request_results++;
      write_pos++;
    end
  endtask

  // The newest position is held back, since a following dot may still mark it.
  task automatic hold_position(input logic [7:0] glyph);
    if (held_valid)
      emit_position(held_glyph);
    held_glyph    = glyph | {7'd0, colon_pending};
    held_valid    = 1'b1;
    colon_pending = 1'b0;
  endtask

  task automatic clear_encoder_state();
    held_glyph    = 8'h00;
    held_valid    = 1'b0;
    write_pos     = 0;
    colon_pending = 1'b0;
  endtask

  task automatic encode_request(input text_req_t req);
    logic first_blank;
    request_results = 0;
    if (req.op == OP_END) begin
      // Flush the held position, blank the rest; a waiting colon dot marks
      // the first blank only.
      if (held_valid)
        emit_position(held_glyph);
      first_blank = 1'b1;
      while (write_pos < NUM_DIGITS) begin
        emit_position({7'd0, first_blank & colon_pending});
        first_blank = 1'b0;
      end
      if (request_results > 0)
        expected_positions[expected_positions.size() - 1].last = 1'b1;
      clear_encoder_state();
    end else if (req.ch == CHAR_DOT) begin
      held_glyph[0] = held_glyph[0] | held_valid;
    end else if (req.ch == CHAR_COLON) begin
      held_glyph[0] = held_glyph[0] | held_valid;
      colon_pending = 1'b1;
    end else if (req.ch == CHAR_PERCENT) begin
      if (held_valid)
        emit_position(held_glyph);
      held_valid = 1'b0;
      emit_position(GLYPH_PCT_LEFT);
      hold_position(GLYPH_PCT_RIGHT);
    end else begin
      hold_position(glyph_of_char(req.ch));
    end
  endtask

  task automatic queue_text(input logic op, input logic [7:0] ch);
    text_req_t r;
    r.op = op;
    r.ch = ch;
    text_queue.push_back(r);
  endtask

  // Mostly characters that the encoder knows, now and then any code at all.
  function automatic logic [7:0] pick_text_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CHAR_ZERO + 8'($urandom_range(9));
    if (r < 55) return CHAR_SIGN_LO + 8'($urandom_range(60));
    if (r < 63) return CHAR_DOT;
    if (r < 70) return CHAR_COLON;
    if (r < 76) return CHAR_PERCENT;
    if (r < 86) begin
      case ($urandom_range(5))
        0: return CHAR_STAR;
        1: return CHAR_MINUS;
        2: return CHAR_QUOTE;
        3: return CHAR_SLASH;
        4: return CHAR_EQUAL;
        default: return 8'd32;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Idling runs in four phases across the stimulus: none, a slow sender,
  // a slow receiver, then light idling on both sides.
  function automatic int idle_percent(input logic receiver_side);
    case (accepted_requests * 4 / total_requests)
      0:       return 0;
      1:       return receiver_side ? 0 : 52;
      2:       return receiver_side ? 52 : 0;
      default: return 9;
    endcase
  endfunction

  // Driver: a request is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    text_req_t next_req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_request('{op: s_axis_tuser, ch: s_axis_tdata});
        accepted_requests++;
        if (s_axis_tuser == OP_END)
          end_requests++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (text_queue.size() > 0 && $urandom_range(99) >= idle_percent(1'b0)) begin
          next_req = text_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_req.ch;
          s_axis_tuser  <= next_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each accepted position is checked against the oldest expectation.
  always @(posedge clk) begin
    position_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_positions++;
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected position, expected none, got index %0d segments %02h",
                   $time, m_axis_tdata[2:0], m_axis_tdata[10:3]);
          errors++;
        end else begin
          want = expected_positions.pop_front();
          if (m_axis_tdata[2:0] !== want.digit_index) begin
            $display("%0t: digit_index expected %0d, got %0d",
                     $time, want.digit_index, m_axis_tdata[2:0]);
            errors++;
          end
          if (m_axis_tdata[10:3] !== want.segments) begin
            $display("%0t: segments expected %02h, got %02h",
                     $time, want.segments, m_axis_tdata[10:3]);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_percent(1'b1));
    end
  end

  // Watchdog on cycles in which neither stream moves a request.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d positions still expected",
               $time, quiet_cycles, expected_positions.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int seq_len;
    clear_encoder_state();

    // Directed text: dots and colons in all their positions, a percent sign,
    // the edges of the glyph ranges, unknown codes and running off the end
    // of the display, then an end with nothing left to emit.
    queue_text(OP_CHAR, CHAR_ZERO);
    queue_text(OP_CHAR, CHAR_DOT);
    queue_text(OP_CHAR, CHAR_NINE);
    queue_text(OP_CHAR, CHAR_COLON);
    queue_text(OP_CHAR, CHAR_DOT);        // dot straight after a colon
    queue_text(OP_CHAR, CHAR_SIGN_LO);
    queue_text(OP_CHAR, CHAR_COLON);
    queue_text(OP_CHAR, CHAR_COLON);      // colon straight after a colon
    queue_text(OP_CHAR, CHAR_PERCENT);
    queue_text(OP_CHAR, CHAR_SIGN_HI);
    queue_text(OP_CHAR, 8'd126);          // first code of the blank band
    queue_text(OP_CHAR, 8'd175);
    queue_text(OP_CHAR, 8'd176);
    queue_text(OP_CHAR, CHAR_STAR);
    queue_text(OP_CHAR, CHAR_MINUS);
    queue_text(OP_CHAR, CHAR_QUOTE);
    queue_text(OP_CHAR, CHAR_SLASH);
    queue_text(OP_CHAR, CHAR_EQUAL);
    queue_text(OP_CHAR, 8'd0);
    queue_text(OP_CHAR, 8'd255);
    queue_text(OP_CHAR, CHAR_COLON);
    queue_text(OP_END, 8'hFF);
    // A leading dot is ignored; a leading colon still marks the first blank.
    queue_text(OP_CHAR, CHAR_DOT);
    queue_text(OP_CHAR, CHAR_COLON);
    queue_text(OP_END, 8'h00);

    // Random part: mostly whole texts closed by an end request, with some
    // loose noise requests in between.
    while (text_queue.size() < TEXT_REQUESTS) begin
      if ($urandom_range(9) < 8) begin
        seq_len = $urandom_range(10);
        repeat (seq_len) queue_text(OP_CHAR, pick_text_char());
        queue_text(OP_END, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_text(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
    total_requests = text_queue.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d text requests (%0d end markers), checked %0d display positions",
             accepted_requests, end_requests, checked_positions);
    $display("under four idling phases; %0d mismatches, %0d positions left over",
             errors, expected_positions.size());
    if (errors == 0 && expected_positions.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ste_pkg.sv
rtl/ste_front.sv
rtl/ste_queue.sv
rtl/ste_back.sv
rtl/segment_text_encoder.sv
bench/tb.sv
